// File: sv/command_history_ring_top_macros.svh
// Assertion macros shared by the checker of the command history ring.
`ifndef COMMAND_HISTORY_RING_TOP_MACROS_SVH
`define COMMAND_HISTORY_RING_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define CHR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define CHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/chr_pkg.sv
`default_nettype none
package chr_pkg;

  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int DEF_LINE_MAX      = 64;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_END   = 3'd1,
    OP_UP    = 3'd2,
    OP_DOWN  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CHAR    = 3'd0,
    ST_NOHIST  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_STORED  = 3'd3,
    ST_DUP     = 3'd4,
    ST_IGNORED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELEN,
    S_CMP,
    S_COPY,
    S_NADDR,
    S_NLEN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] ch_res;
    status_t    status;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// File: sv/chr_ram.sv
`default_nettype none
module chr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/chr_ctrl.sv
`default_nettype none
module chr_ctrl #(
  parameter int HISTORY_DEPTH = 16,
  parameter int LINE_MAX      = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  input  wire logic [2:0]                              op,
  input  wire logic [7:0]                              ch,
  output logic                                         busy,
  output logic                                         valid,
  output chr_pkg::res_t                                res,
  // length memory
  output logic                                         len_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0]             len_waddr,
  output logic [$clog2(LINE_MAX)-1:0]                  len_wdata,
  output logic [$clog2(HISTORY_DEPTH)-1:0]             len_raddr,
  input  wire logic [$clog2(LINE_MAX)-1:0]             len_q,
  // staging memory
  output logic                                         stg_we,
  output logic [$clog2(LINE_MAX)-1:0]                  stg_waddr,
  output logic [7:0]                                   stg_wdata,
  output logic [$clog2(LINE_MAX)-1:0]                  stg_raddr,
  input  wire logic [7:0]                              stg_q,
  // line store memory
  output logic                                         str_we,
  output logic [$clog2(HISTORY_DEPTH*LINE_MAX)-1:0]    str_waddr,
  output logic [7:0]                                   str_wdata,
  output logic [$clog2(HISTORY_DEPTH*LINE_MAX)-1:0]    str_raddr,
  input  wire logic [7:0]                              str_q
);
  import chr_pkg::*;

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int IW = $clog2(LINE_MAX);
  localparam int AW = $clog2(HISTORY_DEPTH * LINE_MAX);
  localparam logic [SW:0]   DEPTH_W  = (SW + 1)'(HISTORY_DEPTH);
  localparam logic [SW:0]   DEPTH_M1 = (SW + 1)'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(HISTORY_DEPTH);
  localparam logic [IW-1:0] KEEP_MAX = IW'(LINE_MAX - 1);
  localparam logic [AW-1:0] LINE_A   = AW'(LINE_MAX);

  state_t        state, state_next;
  logic [SW-1:0] head, head_next;
  logic [CW-1:0] entries, entries_next;
  logic          browsing, browsing_next;
  logic [SW-1:0] offset, offset_next;
  logic [IW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic [SW-1:0] sel_slot, sel_slot_next;
  logic [IW-1:0] issue_idx, issue_idx_next;
  logic [IW-1:0] rd_idx, rd_idx_next;
  logic          rd_vld, rd_vld_next;
  logic          mism, mism_next;
  logic [IW-1:0] len, len_next;
  logic          valid_next;
  res_t          res_next;

  logic [SW-1:0] rd_off;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot_cur;
  logic [IW-1:0] loop_n;
  logic          issuing;
  logic          loop_done;
  logic          accept;
  op_t           op_c;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign op_c   = op_t'(op);

  // Locate the slot that lies rd_off entries behind the newest one
  assign rd_off   = (state == S_IDLE) ? '0 : offset;
  assign slot_sum = {1'b0, head} + (DEPTH_M1 - {1'b0, rd_off});
  assign slot_cur = (slot_sum >= DEPTH_W) ? SW'(slot_sum - DEPTH_W) : slot_sum[SW-1:0];

  // Byte loop over a line: issue one read a cycle, data arriving in the cycle after
  assign loop_n    = (state == S_EMIT) ? len : count;
  assign issuing   = (issue_idx != loop_n);
  assign loop_done = !issuing && !rd_vld;

  // Memory ports
  assign len_raddr = slot_cur;
  assign len_we    = (state == S_COPY) && loop_done;
  assign len_waddr = head;
  assign len_wdata = count;

  assign stg_we    = accept && (op_c == OP_ADD) && (ch != 8'd0) && (count < KEEP_MAX);
  assign stg_waddr = count;
  assign stg_wdata = ch;
  assign stg_raddr = issue_idx;

  assign str_raddr = AW'(sel_slot) * LINE_A + AW'(issue_idx);
  assign str_we    = (state == S_COPY) && rd_vld;
  assign str_waddr = AW'(head) * LINE_A + AW'(rd_idx);
  assign str_wdata = stg_q;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      entries  <= '0;
      browsing <= 1'b0;
      offset   <= '0;
      count    <= '0;
      ovf      <= 1'b0;
      rd_vld   <= 1'b0;
      valid    <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      entries  <= entries_next;
      browsing <= browsing_next;
      offset   <= offset_next;
      count    <= count_next;
      ovf      <= ovf_next;
      rd_vld   <= rd_vld_next;
      valid    <= valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    sel_slot  <= sel_slot_next;
    issue_idx <= issue_idx_next;
    rd_idx    <= rd_idx_next;
    mism      <= mism_next;
    len       <= len_next;
    res       <= res_next;
  end

  // Next state and results
  always_comb begin
    state_next     = state;
    head_next      = head;
    entries_next   = entries;
    browsing_next  = browsing;
    offset_next    = offset;
    count_next     = count;
    ovf_next       = ovf;
    sel_slot_next  = sel_slot;
    issue_idx_next = issue_idx;
    rd_idx_next    = issue_idx;
    rd_vld_next    = 1'b0;
    mism_next      = mism;
    len_next       = len;
    valid_next     = 1'b0;
    res_next       = res;

    unique case (state)
      S_IDLE: begin
        issue_idx_next = '0;
        mism_next      = 1'b0;
        sel_slot_next  = slot_cur;
        if (accept) begin
          case (op_c)
            OP_ADD, OP_END: begin
              if (op_c == OP_ADD && ch != 8'd0) begin
                // stage the byte or mark the line as too long
                if (count < KEEP_MAX) begin
                  count_next = count + 1'b1;
                end else begin
                  ovf_next = 1'b1;
                end
              end else if (count == '0) begin
                ovf_next   = 1'b0;
                valid_next = 1'b1;
                res_next   = '{ch_res: 8'd0, status: ST_IGNORED, last: 1'b1};
              end else if (entries != '0 && !ovf) begin
                state_next = S_ELEN;
              end else begin
                state_next = S_COPY;
              end
            end
            OP_UP: begin
              if (entries == '0) begin
                valid_next = 1'b1;
                res_next   = '{ch_res: 8'd0, status: ST_NOHIST, last: 1'b1};
              end else begin
                if (!browsing) begin
                  browsing_next = 1'b1;
                  offset_next   = '0;
                end else if ((CW'(offset) + 1'b1) < entries) begin
                  offset_next = offset + 1'b1;
                end
                state_next = S_NADDR;
              end
            end
            OP_DOWN: begin
              if (!browsing || offset == '0) begin
                browsing_next = 1'b0;
                offset_next   = '0;
                valid_next    = 1'b1;
                res_next      = '{ch_res: 8'd0, status: ST_EMPTY, last: 1'b1};
              end else begin
                offset_next = offset - 1'b1;
                state_next  = S_NADDR;
              end
            end
            OP_CLEAR: begin
              browsing_next = 1'b0;
              offset_next   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ELEN: begin
        // compare bytes only when the newest entry has the same length
        state_next = (len_q == count) ? S_CMP : S_COPY;
      end

      S_CMP: begin
        if (issuing) begin
          issue_idx_next = issue_idx + 1'b1;
        end
        rd_vld_next = issuing;
        if (rd_vld && stg_q != str_q) begin
          mism_next = 1'b1;
        end
        if (loop_done) begin
          issue_idx_next = '0;
          if (mism) begin
            state_next = S_COPY;
          end else begin
            count_next = '0;
            ovf_next   = 1'b0;
            valid_next = 1'b1;
            res_next   = '{ch_res: 8'd0, status: ST_DUP, last: 1'b1};
            state_next = S_IDLE;
          end
        end
      end

      S_COPY: begin
        if (issuing) begin
          issue_idx_next = issue_idx + 1'b1;
        end
        rd_vld_next = issuing;
        if (loop_done) begin
          // file the line and advance the head
          head_next     = (head == SW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
          if (entries != DEPTH_C) begin
            entries_next = entries + 1'b1;
          end
          browsing_next = 1'b0;
          offset_next   = '0;
          count_next    = '0;
          ovf_next      = 1'b0;
          valid_next    = 1'b1;
          res_next      = '{ch_res: 8'd0, status: ST_STORED, last: 1'b1};
          state_next    = S_IDLE;
        end
      end

      S_NADDR: begin
        sel_slot_next = slot_cur;
        state_next    = S_NLEN;
      end

      S_NLEN: begin
        len_next       = len_q;
        issue_idx_next = '0;
        if (len_q == '0) begin
          valid_next = 1'b1;
          res_next   = '{ch_res: 8'd0, status: ST_EMPTY, last: 1'b1};
          state_next = S_IDLE;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        if (issuing) begin
          issue_idx_next = issue_idx + 1'b1;
        end
        rd_vld_next = issuing;
        if (rd_vld) begin
          valid_next = 1'b1;
          res_next   = '{ch_res: str_q, status: ST_CHAR, last: (rd_idx == len - 1'b1)};
        end
        if (loop_done) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/command_history_ring_top.sv
`default_nettype none
// Command history ring. A request is taken when start is high and busy is low.
// Add-char with a nonzero byte gives no result. End, up and down give their
// results on valid/ch_res/status/last, one per cycle, each for exactly one
// cycle; the receiver cannot stall them, so it must take every strobe. A
// request that answers at once (empty line, no history, down past the newest)
// gives its result the cycle after it is taken. Filing a line copies its bytes
// from the staging memory into the line store, after first comparing them with
// the newest entry when that has the same length; browsing an entry reads its
// length and then its bytes, the characters coming in consecutive cycles.
// The line store is one memory with a single read and a single write port,
// read one byte a cycle. No clearing pass follows reset.
module command_history_ring_top #(
  parameter int HISTORY_DEPTH = chr_pkg::DEF_HISTORY_DEPTH,
  parameter int LINE_MAX      = chr_pkg::DEF_LINE_MAX
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] op,
  input  wire logic [7:0] ch,
  output logic            valid,
  output logic [7:0]      ch_res,
  output logic [2:0]      status,
  output logic            last
);
  import chr_pkg::*;

  localparam int SW = $clog2(HISTORY_DEPTH);
  localparam int IW = $clog2(LINE_MAX);
  localparam int AW = $clog2(HISTORY_DEPTH * LINE_MAX);

  res_t          res;
  logic          len_we;
  logic [SW-1:0] len_waddr;
  logic [IW-1:0] len_wdata;
  logic [SW-1:0] len_raddr;
  logic [IW-1:0] len_q;
  logic          stg_we;
  logic [IW-1:0] stg_waddr;
  logic [7:0]    stg_wdata;
  logic [IW-1:0] stg_raddr;
  logic [7:0]    stg_q;
  logic          str_we;
  logic [AW-1:0] str_waddr;
  logic [7:0]    str_wdata;
  logic [AW-1:0] str_raddr;
  logic [7:0]    str_q;

  // Sequencer
  chr_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .LINE_MAX     (LINE_MAX)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .ch       (ch),
    .busy     (busy),
    .valid    (valid),
    .res      (res),
    .len_we   (len_we),
    .len_waddr(len_waddr),
    .len_wdata(len_wdata),
    .len_raddr(len_raddr),
    .len_q    (len_q),
    .stg_we   (stg_we),
    .stg_waddr(stg_waddr),
    .stg_wdata(stg_wdata),
    .stg_raddr(stg_raddr),
    .stg_q    (stg_q),
    .str_we   (str_we),
    .str_waddr(str_waddr),
    .str_wdata(str_wdata),
    .str_raddr(str_raddr),
    .str_q    (str_q)
  );

  // Entry lengths
  chr_ram #(.WIDTH(IW), .DEPTH(HISTORY_DEPTH)) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .raddr(len_raddr),
    .rdata(len_q)
  );

  // Staged line
  chr_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_stg_ram (
    .clk  (clk),
    .we   (stg_we),
    .waddr(stg_waddr),
    .wdata(stg_wdata),
    .raddr(stg_raddr),
    .rdata(stg_q)
  );

  // Line store, one row of LINE_MAX bytes per slot
  chr_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH * LINE_MAX)) u_str_ram (
    .clk  (clk),
    .we   (str_we),
    .waddr(str_waddr),
    .wdata(str_wdata),
    .raddr(str_raddr),
    .rdata(str_q)
  );

  assign ch_res = res.ch_res;
  assign status = res.status;
  assign last   = res.last;

endmodule
`default_nettype wire

// File: sv/chr_checker.sv
`default_nettype none
`include "command_history_ring_top_macros.svh"
module chr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] op,
  input wire logic [7:0] ch,
  input wire logic       valid,
  input wire logic [7:0] ch_res,
  input wire logic [2:0] status,
  input wire logic       last
);
  import chr_pkg::*;

  // A non-character result is a single, final one with a zero byte
  `CHR_ASSERT_SAME(a_status_single, valid && status != ST_CHAR, last && ch_res == 8'd0, "non-character result not final or byte not zero")

  // Characters of one entry come in consecutive cycles
  `CHR_ASSERT_NEXT(a_run_contiguous, valid && !last, valid, "gap inside an entry run")

  // A staged byte gives no result and leaves the block free
  `CHR_ASSERT_NEXT(a_add_quiet, start && !busy && op == OP_ADD && ch != 8'd0, !valid && !busy, "add-char request produced a result or stall")

  // End, up and down either answer at once or hold busy
  `CHR_ASSERT_NEXT(a_answer, start && !busy && (op == OP_END || op == OP_UP || op == OP_DOWN), valid || busy, "request neither answered nor in progress")

endmodule

bind command_history_ring_top chr_checker u_chr_checker (.*);
`default_nettype wire
